// File: sv/tksi_pkg.sv
// ----------------------------------------------------------------------------
// Top-K sorted insert: shared package
// Widths, defaults and the command bundle that runs from the controller to
// the datapath.
// ----------------------------------------------------------------------------
package tksi_pkg;

   localparam int SCORE_W      = 16;   // unsigned 12.4 fixed point
   localparam int RANK_W       = 4;    // rank is reported modulo 16
   localparam int K_SLOTS_DEF  = 10;
   localparam int TAG_BITS_DEF = 10;

   // One command bundle per cycle from the controller.
   typedef struct packed {
      logic              insert;    // insert the incoming word into the table
      logic              pop;       // move slot 0 to the result register, shift up
      logic [RANK_W-1:0] rank;      // rank carried by the popped entry
      logic              pop_last;  // popped entry is the final rank of the run
   } tksi_cmd_type;

endpackage

// File: sv/tksi_if.sv
// ----------------------------------------------------------------------------
// Top-K sorted insert: channel interfaces
// Valid/ready channels for the input words and the ranked result words.
// ----------------------------------------------------------------------------
interface tksi_req_if import tksi_pkg::*; #(
   parameter int TAG_BITS = TAG_BITS_DEF
) ();
   logic                valid;
   logic                ready;
   logic [SCORE_W-1:0]  score;
   logic [TAG_BITS-1:0] tag;
   logic                last_item;

   modport source (output valid, output score, output tag, output last_item,
                   input ready);
   modport sink   (input valid, input score, input tag, input last_item,
                   output ready);
endinterface

interface tksi_rsp_if import tksi_pkg::*; #(
   parameter int TAG_BITS = TAG_BITS_DEF
) ();
   logic                valid;
   logic                ready;
   logic [RANK_W-1:0]   rank;
   logic [SCORE_W-1:0]  ranked_score;
   logic [TAG_BITS-1:0] ranked_tag;
   logic                filled;
   logic                last_rank;

   modport source (output valid, output rank, output ranked_score, output ranked_tag,
                   output filled, output last_rank, input ready);
   modport sink   (input valid, input rank, input ranked_score, input ranked_tag,
                   input filled, input last_rank, output ready);
endinterface

// File: sv/top_k_sorted_insert.sv
// Latency: an input word is inserted into the table in the cycle it is accepted.
// Throughput: one input word per cycle while a set is being collected.
// On a word marked last, K_SLOTS result words follow at one per cycle while the
// result channel does not stall; input is held off until the final rank is loaded.
// Reset (synchronous) empties every slot and clears the result valid.
// ----------------------------------------------------------------------------
// Top-K sorted insert: top level
// Keeps the K_SLOTS highest-scoring words of a set in descending order and
// reports them in rank order when the set ends.
// ----------------------------------------------------------------------------
module top_k_sorted_insert import tksi_pkg::*; #(
   parameter int K_SLOTS  = K_SLOTS_DEF,
   parameter int TAG_BITS = TAG_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   tksi_req_if.sink   req_bus,
   tksi_rsp_if.source rsp_bus
);

   // The controller decides each cycle whether the table takes a new word
   // (insert) or hands its head to the result register (pop). The two never
   // happen in the same cycle, since input is closed while the table drains.
   tksi_cmd_type cmd;

   tksi_ctrl #(
      .K_SLOTS (K_SLOTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_last  (req_bus.last_item),
      .req_ready (req_bus.ready),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .cmd       (cmd)
   );

   // The datapath is a row of compare-and-shift cells. Each cell compares the
   // incoming score with its own entry; the first cell that is empty or
   // strictly beaten takes the new word, and all cells below it take their
   // upper neighbor. Equal scores do not beat, so earlier words keep rank.
   // Draining shifts the table up one slot per result, which also leaves the
   // table empty once the final rank has gone out.
   tksi_dp #(
      .K_SLOTS  (K_SLOTS),
      .TAG_BITS (TAG_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_score  (req_bus.score),
      .req_tag    (req_bus.tag),
      .rsp_rank   (rsp_bus.rank),
      .rsp_score  (rsp_bus.ranked_score),
      .rsp_tag    (rsp_bus.ranked_tag),
      .rsp_filled (rsp_bus.filled),
      .rsp_last   (rsp_bus.last_rank)
   );

endmodule

// File: sv/tksi_ctrl.sv
// ----------------------------------------------------------------------------
// Top-K sorted insert: controller
// Accepts words while collecting, then sequences the drain of the table
// into the result register, one rank per cycle unless the result channel stalls.
// ----------------------------------------------------------------------------
module tksi_ctrl import tksi_pkg::*; #(
   parameter int K_SLOTS = K_SLOTS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_last,
   output logic         req_ready,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output tksi_cmd_type cmd
);

   localparam int CNT_W = (K_SLOTS > 1) ? $clog2(K_SLOTS) : 1;

   typedef enum logic {
      ST_COLLECT,
      ST_DRAIN
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             req_ready_ff, req_ready_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             accept;
   logic             pop;
   logic             at_last;

   assign accept  = req_valid && req_ready_ff;
   assign pop     = (state_ff == ST_DRAIN) && (!rsp_valid_ff || rsp_ready);
   assign at_last = (cnt_ff == CNT_W'(K_SLOTS - 1));

   always_comb begin
      cmd.insert   = accept;
      cmd.pop      = pop;
      cmd.rank     = RANK_W'(cnt_ff);
      cmd.pop_last = at_last;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      req_ready_in = req_ready_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            if (accept && req_last) begin
               state_in     = ST_DRAIN;
               req_ready_in = 1'b0;
               cnt_in       = '0;
            end
         end
         ST_DRAIN: begin
            if (pop) begin
               if (at_last) begin
                  state_in     = ST_COLLECT;
                  req_ready_in = 1'b1;
                  cnt_in       = '0;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in     = ST_COLLECT;
            req_ready_in = 1'b1;
            cnt_in       = '0;
         end
      endcase

      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         cnt_ff       <= '0;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         req_ready_ff <= req_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: sv/tksi_dp.sv
// ----------------------------------------------------------------------------
// Top-K sorted insert: datapath
// A row of compare-and-shift cells holding the table in descending order,
// plus the result register that the table drains into.
// ----------------------------------------------------------------------------
module tksi_dp import tksi_pkg::*; #(
   parameter int K_SLOTS  = K_SLOTS_DEF,
   parameter int TAG_BITS = TAG_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  tksi_cmd_type        cmd,
   input  logic [SCORE_W-1:0]  req_score,
   input  logic [TAG_BITS-1:0] req_tag,
   output logic [RANK_W-1:0]   rsp_rank,
   output logic [SCORE_W-1:0]  rsp_score,
   output logic [TAG_BITS-1:0] rsp_tag,
   output logic                rsp_filled,
   output logic                rsp_last
);

   logic [SCORE_W-1:0]  score_ff [K_SLOTS];
   logic [SCORE_W-1:0]  score_in [K_SLOTS];
   logic [TAG_BITS-1:0] tag_ff   [K_SLOTS];
   logic [TAG_BITS-1:0] tag_in   [K_SLOTS];
   logic [K_SLOTS-1:0]  valid_ff, valid_in;
   logic [K_SLOTS-1:0]  beat;

   logic [RANK_W-1:0]   out_rank_ff;
   logic [SCORE_W-1:0]  out_score_ff;
   logic [TAG_BITS-1:0] out_tag_ff;
   logic                out_filled_ff;
   logic                out_last_ff;

   // Because the table is sorted and filled from the top, beat is a
   // thermometer code: every slot below the insertion point is beaten too.
   always_comb begin
      for (int i = 0; i < K_SLOTS; i++) begin
         beat[i] = !valid_ff[i] || (req_score > score_ff[i]);
      end
   end

   for (genvar g = 0; g < K_SLOTS; g++) begin : g_cell
      logic              up_beat;
      logic [SCORE_W-1:0]  dn_score;
      logic [TAG_BITS-1:0] dn_tag;
      logic                dn_valid;

      if (g == 0) begin : g_head
         assign up_beat = 1'b0;
      end else begin : g_body
         assign up_beat = beat[g-1];
      end

      if (g == K_SLOTS - 1) begin : g_tail
         assign dn_score = '0;
         assign dn_tag   = '0;
         assign dn_valid = 1'b0;
      end else begin : g_inner
         assign dn_score = score_ff[g+1];
         assign dn_tag   = tag_ff[g+1];
         assign dn_valid = valid_ff[g+1];
      end

      always_comb begin
         score_in[g] = score_ff[g];
         tag_in[g]   = tag_ff[g];
         valid_in[g] = valid_ff[g];
         if (cmd.insert) begin
            if (up_beat) begin
               score_in[g] = score_ff[g-((g > 0) ? 1 : 0)];
               tag_in[g]   = tag_ff[g-((g > 0) ? 1 : 0)];
               valid_in[g] = valid_ff[g-((g > 0) ? 1 : 0)];
            end else if (beat[g]) begin
               score_in[g] = req_score;
               tag_in[g]   = req_tag;
               valid_in[g] = 1'b1;
            end
         end else if (cmd.pop) begin
            score_in[g] = dn_score;
            tag_in[g]   = dn_tag;
            valid_in[g] = dn_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < K_SLOTS; i++) begin
         score_ff[i] <= score_in[i];
         tag_ff[i]   <= tag_in[i];
      end
   end

   // Empty slots report zero payload regardless of what the cell holds.
   always_ff @(posedge clock) begin
      if (cmd.pop) begin
         out_rank_ff   <= cmd.rank;
         out_score_ff  <= valid_ff[0] ? score_ff[0] : '0;
         out_tag_ff    <= valid_ff[0] ? tag_ff[0] : '0;
         out_filled_ff <= valid_ff[0];
         out_last_ff   <= cmd.pop_last;
      end
   end

   assign rsp_rank   = out_rank_ff;
   assign rsp_score  = out_score_ff;
   assign rsp_tag    = out_tag_ff;
   assign rsp_filled = out_filled_ff;
   assign rsp_last   = out_last_ff;

endmodule

// File: sim/tksi_rank_checker.sv
// ----------------------------------------------------------------------------
// Top-K sorted insert: ranking checker
// Watches the input and result channels, keeps its own copy of the ranking
// table and compares every accepted result word against the oldest expected
// one.
// ----------------------------------------------------------------------------
module tksi_rank_checker import tksi_pkg::*; #(
   parameter int K_SLOTS  = K_SLOTS_DEF,
   parameter int TAG_BITS = TAG_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   tksi_req_if  req_mon,
   tksi_rsp_if  rsp_mon,
   output int   error_count,
   output int   pending_words
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [RANK_W-1:0]   rank;
      logic [SCORE_W-1:0]  score;
      logic [TAG_BITS-1:0] tag;
      logic                filled;
      logic                last_rank;
   } rank_word_type;

   logic [SCORE_W-1:0]  table_score [K_SLOTS];
   logic [TAG_BITS-1:0] table_tag   [K_SLOTS];
   logic                table_held  [K_SLOTS];
   rank_word_type       expected_ranks [$];
   int                  mismatches = 0;

   initial begin
      error_count   = 0;
      pending_words = 0;
   end

   function automatic void clear_table();
      for (int i = 0; i < K_SLOTS; i++) begin
         table_score[i] = '0;
         table_tag[i]   = '0;
         table_held[i]  = 1'b0;
      end
   endfunction

   // The word lands in the first slot that is empty or that it strictly beats;
   // everything below moves down one and the bottom entry falls off.
   function automatic void place_word(input logic [SCORE_W-1:0] sc,
                                      input logic [TAG_BITS-1:0] tg);
      int pos;
      pos = -1;
      for (int i = 0; i < K_SLOTS; i++) begin
         if (!table_held[i] || sc > table_score[i]) begin
            pos = i;
            break;
         end
      end
      if (pos >= 0) begin
         for (int i = K_SLOTS - 1; i > pos; i--) begin
            table_score[i] = table_score[i-1];
            table_tag[i]   = table_tag[i-1];
            table_held[i]  = table_held[i-1];
         end
         table_score[pos] = sc;
         table_tag[pos]   = tg;
         table_held[pos]  = 1'b1;
      end
   endfunction

   function automatic void queue_ranks();
      rank_word_type w;
      for (int k = 0; k < K_SLOTS; k++) begin
         w.rank      = RANK_W'(k);
         w.score     = table_held[k] ? table_score[k] : '0;
         w.tag       = table_held[k] ? table_tag[k] : '0;
         w.filled    = table_held[k];
         w.last_rank = (k == K_SLOTS - 1);
         expected_ranks.push_back(w);
      end
      clear_table();
   endfunction

   function automatic bit field_ok(input string name, input logic [31:0] want,
                                   input logic [31:0] got);
      if (got !== want)
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, name, want, got);
      return got === want;
   endfunction

   always @(posedge clock) begin
      rank_word_type seen;
      rank_word_type want;
      bit            good;
      if (reset) begin
         clear_table();
         expected_ranks.delete();
      end else begin
         // Results are checked before the input word of the same edge is
         // taken in, so a word from an earlier set is never matched late.
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.rank      = rsp_mon.rank;
            seen.score     = rsp_mon.ranked_score;
            seen.tag       = rsp_mon.ranked_tag;
            seen.filled    = rsp_mon.filled;
            seen.last_rank = rsp_mon.last_rank;
            if (expected_ranks.size() == 0) begin
               $display("%0t: unexpected result word, expected none, actual %p",
                        $time, seen);
               mismatches++;
            end else begin
               want = expected_ranks.pop_front();
               good = field_ok("rank", 32'(want.rank), 32'(seen.rank))
                    & field_ok("ranked_score", 32'(want.score), 32'(seen.score))
                    & field_ok("ranked_tag", 32'(want.tag), 32'(seen.tag))
                    & field_ok("filled", 32'(want.filled), 32'(seen.filled))
                    & field_ok("last_rank", 32'(want.last_rank),
                               32'(seen.last_rank));
               if (!good)
                  mismatches++;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            place_word(req_mon.score, req_mon.tag);
            if (req_mon.last_item)
               queue_ranks();
         end
      end
      error_count   <= mismatches;
      pending_words <= expected_ranks.size();
   end

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// Top-K sorted insert: testbench top
// Drives sets of scored words into the block with random idling on both
// channels, holds the result channel off once for a long stretch, and reports
// the verdict from the ranking checker.
// ----------------------------------------------------------------------------
module tb;
   import tksi_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES = 200;

   logic clock;
   logic reset;

   tksi_req_if req_if ();
   tksi_rsp_if rsp_if ();

   int check_errors;
   int ranks_pending;

   // Shared knobs between the input side and the result side.
   bit idle_enable  = 1'b1;   // random idle bursts allowed on both channels
   bit hold_results = 1'b0;   // request one long hold-off of the result channel

   top_k_sorted_insert u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   tksi_rank_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_if),
      .rsp_mon       (rsp_if),
      .error_count   (check_errors),
      .pending_words (ranks_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Reset is held at the start and never raised again.
   initial begin
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // A slowest correct run, with every result word stalled by a full idle
   // burst, stays well under this bound, so the bound only fires when the
   // block hangs.
   initial begin
      #200000;
      $display("== FAIL ==");
      $finish;
   end

   // Result side. Each pass through the loop starts at a rising edge and
   // drives ready exactly once, so a burst never fights with the next one.
   // The long hold is counted here and lets the block back up far enough
   // that it has to refuse input words.
   initial begin
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_results) begin
            hold_results = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (idle_enable && $urandom_range(0, 2) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            repeat (idle_enable ? $urandom_range(1, 24) : 1) @(posedge clock);
         end
      end
   end

   // Scores lean on the extremes and on a narrow band near zero so that
   // equal scores, and therefore tie handling, come up often.
   function automatic logic [SCORE_W-1:0] pick_score();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return SCORE_W'($urandom_range(0, 7));
         default: return SCORE_W'($urandom);
      endcase
   endfunction

   // Offers one word and returns at the edge where it is taken. An idle
   // burst before the word puts junk on the payload with valid low.
   task automatic send_word(input logic [SCORE_W-1:0] sc,
                            input logic [TAG_BITS_DEF-1:0] tg,
                            input logic fin);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_if.valid     <= 1'b0;
         req_if.score     <= SCORE_W'($urandom);
         req_if.tag       <= TAG_BITS_DEF'($urandom);
         req_if.last_item <= 1'($urandom);
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.score     <= sc;
      req_if.tag       <= tg;
      req_if.last_item <= fin;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // One complete set with random content, closed by a word marked last.
   task automatic send_set(input int len);
      for (int i = 0; i < len; i++)
         send_word(pick_score(), TAG_BITS_DEF'($urandom), i == len - 1);
   endtask

   initial begin
      int sent;
      int len;
      req_if.valid     <= 1'b0;
      req_if.score     <= '0;
      req_if.tag       <= '0;
      req_if.last_item <= 1'b0;
      sent = 0;
      @(posedge clock);
      while (reset) @(posedge clock);

      // A set of one word with score zero: it still takes the top slot, and
      // the other nine ranks come back empty.
      send_word(16'h0000, 10'h000, 1'b1);

      // Thirteen words into ten slots. Equal scores must keep the earlier
      // word ahead, once the table is full a word that beats nothing is
      // dropped, and a word that beats the zero entries pushes the bottom
      // one out. The closing word is itself a loser on a full table.
      send_word(16'hFFFF, 10'h3FF, 1'b0);
      send_word(16'h8000, 10'h001, 1'b0);
      send_word(16'h8000, 10'h002, 1'b0);
      send_word(16'h0000, 10'h003, 1'b0);
      send_word(16'h0000, 10'h004, 1'b0);
      send_word(16'h1234, 10'h005, 1'b0);
      send_word(16'h0001, 10'h006, 1'b0);
      send_word(16'h7FFF, 10'h007, 1'b0);
      send_word(16'hFFFF, 10'h008, 1'b0);
      send_word(16'h0000, 10'h009, 1'b0);
      send_word(16'h0000, 10'h00A, 1'b0);
      send_word(16'h0002, 10'h00B, 1'b0);
      send_word(16'h0000, 10'h2AA, 1'b1);

      // Rising scores: every word lands in slot 0 and shifts the whole
      // table, and the eleventh shifts the first one out.
      for (int i = 1; i <= 11; i++)
         send_word(SCORE_W'(i), TAG_BITS_DEF'(10'h155 + i), i == 11);

      // Long hold on the result side. Input is quieted until the hold has
      // begun, then two sets are offered without gaps so the block fills
      // its output and has to refuse the second set for a while.
      req_if.valid <= 1'b0;
      idle_enable  = 1'b0;
      hold_results = 1'b1;
      while (hold_results) @(posedge clock);
      send_set(6);
      send_set(8);
      idle_enable = 1'b1;

      // Random sets of mixed length with idling on both sides.
      while (sent < 70) begin
         len = $urandom_range(1, 20);
         send_set(len);
         sent += len;
      end

      // Closing stretch with both channels running flat out.
      idle_enable = 1'b0;
      while (sent < 90) begin
         len = $urandom_range(1, 12);
         send_set(len);
         sent += len;
      end
      req_if.valid <= 1'b0;

      // A wait for a clock edge lets the checker's counts catch up with the last word.
      @(posedge clock);
      while (ranks_pending != 0) @(posedge clock);
      repeat (K_SLOTS_DEF + 10) @(posedge clock);

      if (check_errors == 0 && ranks_pending == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
